### src/pcbe_pkg.sv
`default_nettype none

package pcbe_pkg;

  localparam int unsigned BUS_COUNT_DEF      = 256;
  localparam int unsigned DEVICE_COUNT_DEF   = 32;
  localparam int unsigned FUNCTION_COUNT_DEF = 8;

  localparam logic [7:0]  REG_ID     = 8'h00;
  localparam logic [7:0]  REG_CLASS  = 8'h08;
  localparam logic [7:0]  REG_HEADER = 8'h0C;
  localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
  localparam int unsigned MF_BIT = 23;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ID     = 2'd1,
    PH_CLASS  = 2'd2,
    PH_HEADER = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] cfg_address;
    logic [7:0]  bus_number;
    logic [4:0]  device_number;
    logic [2:0]  function_number;
    logic [15:0] vendor_id;
    logic [15:0] device_id;
    logic [7:0]  class_code;
    logic [7:0]  subclass_code;
    logic        multi_function;
    logic        last;
  } res_t;

  function automatic res_t mk_read(logic [7:0] bus, logic [4:0] dev, logic [2:0] fn,
                                   logic [7:0] reg_off);
    res_t r;
    r = '0;
    r.kind = KIND_READ;
    r.cfg_address = {1'b1, 7'b0, bus, dev, fn, reg_off};
    r.last = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_done();
    res_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.last = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

### src/pcbe_step.sv
`default_nettype none

module pcbe_step #(
  parameter int unsigned BUS_COUNT      = pcbe_pkg::BUS_COUNT_DEF,
  parameter int unsigned DEVICE_COUNT   = pcbe_pkg::DEVICE_COUNT_DEF,
  parameter int unsigned FUNCTION_COUNT = pcbe_pkg::FUNCTION_COUNT_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire logic           req_type_i,
  input  wire logic [31:0]    read_data_i,
  output pcbe_pkg::res_t      res0_o,
  output pcbe_pkg::res_t      res1_o,
  output logic [1:0]          push_n_o
);

  localparam logic [8:0] BusLim = 9'(BUS_COUNT);
  localparam logic [5:0] DevLim = 6'(DEVICE_COUNT);
  localparam logic [3:0] FnLim  = 4'(FUNCTION_COUNT);

  logic [7:0]       bus_q, bus_d;
  logic [4:0]       dev_q, dev_d;
  logic [2:0]       fn_q, fn_d;
  pcbe_pkg::phase_e phase_q, phase_d;
  logic [31:0]      held_id_q, held_id_d;
  logic [15:0]      held_class_q, held_class_d;

  logic       adv_skip;
  logic [3:0] f_inc;
  logic [5:0] d_inc;
  logic [8:0] b_inc;
  logic [8:0] nb_w;
  logic [4:0] nd;
  logic [2:0] nf;
  logic       adv_ok;
  logic [7:0] adv_bus;
  logic [4:0] adv_dev;
  logic [2:0] adv_fn;
  logic       vendor_none;
  pcbe_pkg::res_t adv_res;

  assign vendor_none = (read_data_i[15:0] == pcbe_pkg::VENDOR_NONE);
  assign adv_skip = (phase_q == pcbe_pkg::PH_HEADER) && (fn_q == 3'd0)
                    && !read_data_i[pcbe_pkg::MF_BIT];

  // step to the next position
  always_comb begin
    f_inc = {1'b0, fn_q} + 4'd1;
    d_inc = {1'b0, dev_q} + 6'd1;
    b_inc = {1'b0, bus_q} + 9'd1;
    if (adv_skip || (f_inc >= FnLim)) begin
      nf = 3'd0;
      if (d_inc >= DevLim) begin
        nd   = 5'd0;
        nb_w = b_inc;
      end else begin
        nd   = d_inc[4:0];
        nb_w = {1'b0, bus_q};
      end
    end else begin
      nf   = f_inc[2:0];
      nd   = dev_q;
      nb_w = {1'b0, bus_q};
    end
    adv_ok  = (nb_w < BusLim);
    adv_bus = adv_ok ? nb_w[7:0] : 8'd0;
    adv_dev = adv_ok ? nd : 5'd0;
    adv_fn  = adv_ok ? nf : 3'd0;
    adv_res = adv_ok ? pcbe_pkg::mk_read(adv_bus, adv_dev, adv_fn, pcbe_pkg::REG_ID)
                     : pcbe_pkg::mk_done();
  end

  // next state
  always_comb begin
    bus_d        = bus_q;
    dev_d        = dev_q;
    fn_d         = fn_q;
    phase_d      = phase_q;
    held_id_d    = held_id_q;
    held_class_d = held_class_q;
    if (fire_i) begin
      if (!req_type_i) begin
        bus_d   = 8'd0;
        dev_d   = 5'd0;
        fn_d    = 3'd0;
        phase_d = pcbe_pkg::PH_ID;
      end else begin
        unique case (phase_q)
          pcbe_pkg::PH_ID: begin
            if (vendor_none) begin
              bus_d   = adv_bus;
              dev_d   = adv_dev;
              fn_d    = adv_fn;
              phase_d = adv_ok ? pcbe_pkg::PH_ID : pcbe_pkg::PH_IDLE;
            end else begin
              held_id_d = read_data_i;
              phase_d   = pcbe_pkg::PH_CLASS;
            end
          end
          pcbe_pkg::PH_CLASS: begin
            held_class_d = read_data_i[31:16];
            phase_d      = pcbe_pkg::PH_HEADER;
          end
          pcbe_pkg::PH_HEADER: begin
            bus_d   = adv_bus;
            dev_d   = adv_dev;
            fn_d    = adv_fn;
            phase_d = adv_ok ? pcbe_pkg::PH_ID : pcbe_pkg::PH_IDLE;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  // results
  always_comb begin
    res0_o   = '0;
    res1_o   = '0;
    push_n_o = 2'd0;
    if (fire_i) begin
      if (!req_type_i) begin
        res0_o   = pcbe_pkg::mk_read(8'd0, 5'd0, 3'd0, pcbe_pkg::REG_ID);
        push_n_o = 2'd1;
      end else begin
        unique case (phase_q)
          pcbe_pkg::PH_ID: begin
            res0_o   = vendor_none ? adv_res
                       : pcbe_pkg::mk_read(bus_q, dev_q, fn_q, pcbe_pkg::REG_CLASS);
            push_n_o = 2'd1;
          end
          pcbe_pkg::PH_CLASS: begin
            res0_o   = pcbe_pkg::mk_read(bus_q, dev_q, fn_q, pcbe_pkg::REG_HEADER);
            push_n_o = 2'd1;
          end
          pcbe_pkg::PH_HEADER: begin
            res0_o.kind            = pcbe_pkg::KIND_RECORD;
            res0_o.bus_number      = bus_q;
            res0_o.device_number   = dev_q;
            res0_o.function_number = fn_q;
            res0_o.vendor_id       = held_id_q[15:0];
            res0_o.device_id       = held_id_q[31:16];
            res0_o.class_code      = held_class_q[15:8];
            res0_o.subclass_code   = held_class_q[7:0];
            res0_o.multi_function  = read_data_i[pcbe_pkg::MF_BIT];
            res0_o.last            = 1'b0;
            res1_o                 = adv_res;
            push_n_o               = 2'd2;
          end
          default: begin
            push_n_o = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q        <= 8'd0;
      dev_q        <= 5'd0;
      fn_q         <= 3'd0;
      phase_q      <= pcbe_pkg::PH_IDLE;
      held_id_q    <= 32'd0;
      held_class_q <= 16'd0;
    end else begin
      bus_q        <= bus_d;
      dev_q        <= dev_d;
      fn_q         <= fn_d;
      phase_q      <= phase_d;
      held_id_q    <= held_id_d;
      held_class_q <= held_class_d;
    end
  end

`ifndef ASSERT_OFF
  a_hdr_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && req_type_i && phase_q == pcbe_pkg::PH_HEADER)
    |=> (phase_q == pcbe_pkg::PH_ID || phase_q == pcbe_pkg::PH_IDLE))
    else $error("header reply did not end the function");
  a_start_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !req_type_i)
    |=> (phase_q == pcbe_pkg::PH_ID && bus_q == 8'd0 && dev_q == 5'd0 && fn_q == 3'd0))
    else $error("start did not reset the position");
  a_pair_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_o == 2'd2) |-> (res0_o.kind == pcbe_pkg::KIND_RECORD && res1_o.last))
    else $error("two results without a device record");
`endif

endmodule

`default_nettype wire

### src/pcbe_result_fifo.sv
`default_nettype none

module pcbe_result_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [1:0]     push_n_i,
  input  wire pcbe_pkg::res_t res0_i,
  input  wire pcbe_pkg::res_t res1_i,
  input  wire logic           pop_i,
  output pcbe_pkg::res_t      head_o,
  output logic                not_empty_o,
  output logic                room2_o
);

  localparam int unsigned Depth = 4;

  pcbe_pkg::res_t entry_q [Depth];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       do_pop;

  assign not_empty_o = (count_q != 3'd0);
  assign room2_o     = (count_q <= 3'(Depth - 2));
  assign head_o      = entry_q[rd_ptr_q];
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_n_i;
    rd_ptr_d = rd_ptr_q + {1'b0, do_pop};
    count_d  = count_q + {1'b0, push_n_i} - {2'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      entry_q[wr_ptr_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      entry_q[wr_ptr_q + 2'd1] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> room2_o)
    else $error("result queue written without room");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= 3'(Depth))
    && (wr_ptr_q - rd_ptr_q == count_q[1:0]))
    else $error("queue pointers and count disagree");
`endif

endmodule

`default_nettype wire

### src/pci_config_bus_enumerator.sv
// channel | handshake                 | payload
// --------+---------------------------+-------------------------------------------
// in      | in_valid_i / in_ready_o   | req_type_i, read_data_i
// out     | out_valid_o / out_ready_i | result_kind_o, cfg_address_o, bus_number_o,
//         |                           | device_number_o, function_number_o, vendor_id_o,
//         |                           | device_id_o, class_code_o, subclass_code_o,
//         |                           | multi_function_o, last_o
//
// one input item per cycle while in_ready_o is high; each item is decoded in the cycle it is accepted
// results are registered into a four-entry queue, whose head drives the out channel
// a header reply yields two results, both written to the queue in the same cycle
// in_ready_o is high while the queue has room for two results
// rst_ni clears position, read phase and queue; no clearing pass
`default_nettype none

module pci_config_bus_enumerator #(
  parameter int unsigned BUS_COUNT      = pcbe_pkg::BUS_COUNT_DEF,
  parameter int unsigned DEVICE_COUNT   = pcbe_pkg::DEVICE_COUNT_DEF,
  parameter int unsigned FUNCTION_COUNT = pcbe_pkg::FUNCTION_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [31:0] read_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [31:0]      cfg_address_o,
  output logic [7:0]       bus_number_o,
  output logic [4:0]       device_number_o,
  output logic [2:0]       function_number_o,
  output logic [15:0]      vendor_id_o,
  output logic [15:0]      device_id_o,
  output logic [7:0]       class_code_o,
  output logic [7:0]       subclass_code_o,
  output logic             multi_function_o,
  output logic             last_o
);

  logic           fire;
  logic           room2;
  logic [1:0]     push_n;
  pcbe_pkg::res_t res0;
  pcbe_pkg::res_t res1;
  pcbe_pkg::res_t head;

  assign in_ready_o = room2;
  assign fire       = in_valid_i && room2;

  pcbe_step #(
    .BUS_COUNT      (BUS_COUNT),
    .DEVICE_COUNT   (DEVICE_COUNT),
    .FUNCTION_COUNT (FUNCTION_COUNT)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .req_type_i  (req_type_i),
    .read_data_i (read_data_i),
    .res0_o      (res0),
    .res1_o      (res1),
    .push_n_o    (push_n)
  );

  pcbe_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .res0_i      (res0),
    .res1_i      (res1),
    .pop_i       (out_ready_i),
    .head_o      (head),
    .not_empty_o (out_valid_o),
    .room2_o     (room2)
  );

  assign result_kind_o     = head.kind;
  assign cfg_address_o     = head.cfg_address;
  assign bus_number_o      = head.bus_number;
  assign device_number_o   = head.device_number;
  assign function_number_o = head.function_number;
  assign vendor_id_o       = head.vendor_id;
  assign device_id_o       = head.device_id;
  assign class_code_o      = head.class_code;
  assign subclass_code_o   = head.subclass_code;
  assign multi_function_o  = head.multi_function;
  assign last_o            = head.last;

endmodule

`default_nettype wire

### verif/pci_config_bus_enumerator_tb.sv
`timescale 1ns / 1ps

module pci_config_bus_enumerator_tb;

  localparam logic        REQ_START  = 1'b0;
  localparam logic        REQ_DATA   = 1'b1;
  localparam logic [31:0] CFG_ENABLE = 32'h8000_0000;
  localparam int unsigned RANDOM_ITEMS = 1200;

  typedef struct {
    logic        req;
    logic [31:0] data;
    bit          quick;
  } probe_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        req_type_i = 1'b0;
  logic [31:0] read_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [31:0] cfg_address_o;
  logic [7:0]  bus_number_o;
  logic [4:0]  device_number_o;
  logic [2:0]  function_number_o;
  logic [15:0] vendor_id_o;
  logic [15:0] device_id_o;
  logic [7:0]  class_code_o;
  logic [7:0]  subclass_code_o;
  logic        multi_function_o;
  logic        last_o;

  always #5 clk_i = ~clk_i;

  pci_config_bus_enumerator DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .read_data_i      (read_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .cfg_address_o    (cfg_address_o),
    .bus_number_o     (bus_number_o),
    .device_number_o  (device_number_o),
    .function_number_o(function_number_o),
    .vendor_id_o      (vendor_id_o),
    .device_id_o      (device_id_o),
    .class_code_o     (class_code_o),
    .subclass_code_o  (subclass_code_o),
    .multi_function_o (multi_function_o),
    .last_o           (last_o)
  );

  probe_item_t     host_items[$];
  pcbe_pkg::res_t  scan_results_due[$];

  // scan position as predicted from the accepted items
  int unsigned      pos_bus = 0;
  int unsigned      pos_dev = 0;
  int unsigned      pos_fn = 0;
  pcbe_pkg::phase_e await_phase = pcbe_pkg::PH_IDLE;
  logic [31:0]      id_word = '0;
  logic [15:0]      class_bytes = '0;

  int unsigned error_count = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned records_seen = 0;
  int unsigned scans_seen = 0;

  int unsigned    gap_left;
  int unsigned    stall_left;
  int unsigned    in_mode = 1;
  int unsigned    out_mode = 1;
  int unsigned    loads = 0;
  int unsigned    out_cycles = 0;
  bit             sweep_active;
  probe_item_t    loaded;
  pcbe_pkg::res_t head_result;

  function automatic pcbe_pkg::res_t config_read(input logic [7:0] reg_off);
    pcbe_pkg::res_t r;
    r = '0;
    r.kind = pcbe_pkg::KIND_READ;
    r.cfg_address = CFG_ENABLE | (pos_bus << 16) | (pos_dev << 11) | (pos_fn << 8) | reg_off;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic next_position(input bit skip_rest);
    int unsigned b;
    int unsigned d;
    int unsigned f;
    pcbe_pkg::res_t r;
    b = pos_bus;
    d = pos_dev;
    f = pos_fn + 1;
    if (skip_rest || f >= pcbe_pkg::FUNCTION_COUNT_DEF) begin
      f = 0;
      d = d + 1;
      if (d >= pcbe_pkg::DEVICE_COUNT_DEF) begin
        d = 0;
        b = b + 1;
      end
    end
    if (b >= pcbe_pkg::BUS_COUNT_DEF) begin
      pos_bus = 0;
      pos_dev = 0;
      pos_fn = 0;
      await_phase = pcbe_pkg::PH_IDLE;
      r = '0;
      r.kind = pcbe_pkg::KIND_DONE;
      r.last = 1'b1;
      scan_results_due.push_back(r);
    end else begin
      pos_bus = b;
      pos_dev = d;
      pos_fn = f;
      await_phase = pcbe_pkg::PH_ID;
      scan_results_due.push_back(config_read(pcbe_pkg::REG_ID));
    end
  endtask

  task automatic walk_config_space(input logic req, input logic [31:0] data);
    pcbe_pkg::res_t rec;
    logic mf;
    if (req == REQ_START) begin
      pos_bus = 0;
      pos_dev = 0;
      pos_fn = 0;
      await_phase = pcbe_pkg::PH_ID;
      scan_results_due.push_back(config_read(pcbe_pkg::REG_ID));
    end else begin
      case (await_phase)
        pcbe_pkg::PH_ID: begin
          if (data[15:0] == pcbe_pkg::VENDOR_NONE) begin
            next_position(1'b0);
          end else begin
            id_word = data;
            await_phase = pcbe_pkg::PH_CLASS;
            scan_results_due.push_back(config_read(pcbe_pkg::REG_CLASS));
          end
        end
        pcbe_pkg::PH_CLASS: begin
          class_bytes = data[31:16];
          await_phase = pcbe_pkg::PH_HEADER;
          scan_results_due.push_back(config_read(pcbe_pkg::REG_HEADER));
        end
        pcbe_pkg::PH_HEADER: begin
          mf = data[pcbe_pkg::MF_BIT];
          rec = '0;
          rec.kind = pcbe_pkg::KIND_RECORD;
          rec.bus_number = pos_bus[7:0];
          rec.device_number = pos_dev[4:0];
          rec.function_number = pos_fn[2:0];
          rec.vendor_id = id_word[15:0];
          rec.device_id = id_word[31:16];
          rec.class_code = class_bytes[15:8];
          rec.subclass_code = class_bytes[7:0];
          rec.multi_function = mf;
          rec.last = 1'b0;
          scan_results_due.push_back(rec);
          next_position(pos_fn == 0 && !mf);
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 40) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  // most pauses short, a few long; sweep items keep pauses rare
  function automatic int unsigned idle_len(input bit sweep, input int unsigned mode);
    int unsigned roll;
    roll = $urandom_range(99);
    if (sweep) return (roll < 96) ? 0 : $urandom_range(2, 1);
    if (mode == 0) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  task automatic add_item(input logic req, input logic [31:0] data, input bit quick);
    probe_item_t it;
    it.req = req;
    it.data = data;
    it.quick = quick;
    host_items.push_back(it);
  endtask

  task automatic queue_function(input bit present, input bit mf, input bit quick);
    logic [31:0] word;
    word = $urandom;
    if (!present) begin
      word[15:0] = pcbe_pkg::VENDOR_NONE;
      add_item(REQ_DATA, word, quick);
    end else begin
      if (word[15:0] == pcbe_pkg::VENDOR_NONE) word[0] = 1'b0;
      add_item(REQ_DATA, word, quick);
      add_item(REQ_DATA, $urandom, quick);
      word = $urandom;
      word[pcbe_pkg::MF_BIT] = mf;
      add_item(REQ_DATA, word, quick);
    end
  endtask

  task automatic queue_device(input bit quick);
    int unsigned roll;
    int unsigned f;
    roll = $urandom_range(99);
    if (roll < (quick ? 94 : 50)) begin
      queue_function(1'b1, 1'b0, quick);
    end else begin
      // function 0 either absent or multi-function, so all functions get probed
      queue_function(roll < (quick ? 97 : 75), 1'b1, quick);
      for (f = 1; f < pcbe_pkg::FUNCTION_COUNT_DEF; f++) begin
        queue_function(1'($urandom_range(1)), 1'($urandom_range(1)), quick);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_type_i <= REQ_START;
      read_data_i <= '0;
      gap_left <= 0;
      sweep_active <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        walk_config_space(req_type_i, read_data_i);
        items_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (host_items.size() != 0) begin
          loaded = host_items.pop_front();
          if (loads % 40 == 0) in_mode = $urandom_range(3);
          loads++;
          in_valid_i <= 1'b1;
          req_type_i <= loaded.req;
          read_data_i <= loaded.data;
          sweep_active <= loaded.quick;
          gap_left <= idle_len(loaded.quick, in_mode);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (scan_results_due.size() == 0) begin
          report_error($sformatf("result with nothing outstanding, kind %0d", result_kind_o));
        end else begin
          head_result = scan_results_due.pop_front();
          check_field("result_kind", result_kind_o, head_result.kind);
          check_field("cfg_address", cfg_address_o, head_result.cfg_address);
          check_field("bus_number", bus_number_o, head_result.bus_number);
          check_field("device_number", device_number_o, head_result.device_number);
          check_field("function_number", function_number_o, head_result.function_number);
          check_field("vendor_id", vendor_id_o, head_result.vendor_id);
          check_field("device_id", device_id_o, head_result.device_id);
          check_field("class_code", class_code_o, head_result.class_code);
          check_field("subclass_code", subclass_code_o, head_result.subclass_code);
          check_field("multi_function", multi_function_o, head_result.multi_function);
          check_field("last", last_o, head_result.last);
          results_seen++;
          if (head_result.kind == pcbe_pkg::KIND_RECORD) records_seen++;
          if (head_result.kind == pcbe_pkg::KIND_DONE) scans_seen++;
        end
      end
      if (out_cycles % 50 == 0) out_mode = $urandom_range(3);
      out_cycles++;
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
        stall_left <= idle_len(sweep_active, out_mode);
      end
    end
  end

  initial begin
    int unsigned random_base;
    int unsigned n;

    // data while idle, absent functions, present without multi-function,
    // multi-function on a later function, restarts mid-scan
    add_item(REQ_DATA, 32'hFFFF_FFFF, 1'b0);
    add_item(REQ_DATA, 32'h0000_0000, 1'b0);
    add_item(REQ_START, 32'hFFFF_FFFF, 1'b0);
    add_item(REQ_DATA, 32'hFFFF_FFFF, 1'b0);
    add_item(REQ_DATA, 32'h0000_FFFF, 1'b0);
    add_item(REQ_DATA, 32'hFFFF_0000, 1'b0);
    add_item(REQ_DATA, 32'hFFFF_FFFF, 1'b0);
    add_item(REQ_DATA, 32'h0080_0000, 1'b0);
    add_item(REQ_DATA, 32'h0000_0000, 1'b0);
    add_item(REQ_DATA, 32'h0000_0000, 1'b0);
    add_item(REQ_DATA, 32'hFF7F_FFFF, 1'b0);
    add_item(REQ_START, 32'h0000_0000, 1'b0);
    add_item(REQ_DATA, 32'hFFFE_FFFE, 1'b0);
    add_item(REQ_DATA, 32'hFFFF_FFFF, 1'b0);
    add_item(REQ_DATA, 32'h0000_0000, 1'b0);
    add_item(REQ_DATA, 32'h10EC_8139, 1'b0);
    add_item(REQ_START, 32'hFFFF_FFFF, 1'b0);
    add_item(REQ_DATA, 32'h8086_1237, 1'b0);
    add_item(REQ_DATA, 32'h0C03_0000, 1'b0);
    add_item(REQ_DATA, 32'h0080_0000, 1'b0);

    // scans with random device contents, cut short by restarts and noise
    random_base = host_items.size();
    while (host_items.size() - random_base < RANDOM_ITEMS) begin
      add_item(REQ_START, $urandom, 1'b0);
      repeat ($urandom_range(12, 1)) queue_device(1'b0);
      if ($urandom_range(99) < 35) begin
        case ($urandom_range(2))
          0: add_item(REQ_DATA, $urandom, 1'b0);
          1: begin
            add_item(REQ_DATA, {16'($urandom_range(16'hFFFF)), 16'h1AF4}, 1'b0);
            add_item(REQ_DATA, $urandom, 1'b0);
          end
          default: begin
            n = $urandom_range(4, 1);
            repeat (n) add_item(1'($urandom_range(1)), $urandom, 1'b0);
          end
        endcase
      end
    end

    // trailing noise, then one more restart
    add_item(REQ_DATA, $urandom, 1'b0);
    add_item(REQ_DATA, 32'h0000_FFFF, 1'b0);
    add_item(REQ_START, $urandom, 1'b0);
    queue_device(1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (host_items.size() != 0 || in_valid_i || scan_results_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (40) @(posedge clk_i);

    $display("bus scan: %0d items accepted, %0d results checked", items_taken, results_seen);
    $display("bus scan: %0d device records, %0d done results", records_seen, scans_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout: %0d results still outstanding", scan_results_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
